// ===== hdl/pdt_pkg.sv =====
package pdt_pkg;

    // Stream widths.
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;
    localparam int CFG_W     = 32;

    // Input field positions in s_tdata, lowest bit first.
    localparam int SEL_LSB   = 0;
    localparam int TICKS_LSB = 4;
    localparam int INIT_LSB  = 37;
    localparam int EN_BIT    = 70;
    localparam int NOW_LSB   = 71;

    localparam logic [CFG_W-1:0] WRAP_RESET = 32'hFFFF_FFFF;

    // Opcodes carried on s_tuser.
    localparam logic [2:0] OP_REGISTER  = 3'd0;
    localparam logic [2:0] OP_RESTART   = 3'd1;
    localparam logic [2:0] OP_PAUSE     = 3'd2;
    localparam logic [2:0] OP_SET_DELAY = 3'd3;
    localparam logic [2:0] OP_SET_OWN   = 3'd4;
    localparam logic [2:0] OP_SCAN      = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_ACK      = 2'd0;
    localparam logic [1:0] KIND_DISPATCH = 2'd1;
    localparam logic [1:0] KIND_NONE_DUE = 2'd2;

    // Error codes.
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_FULL       = 2'd1;
    localparam logic [1:0] ERR_UNUSED     = 2'd2;
    localparam logic [1:0] ERR_NO_CURRENT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_DELTA,
        ST_COMPARE,
        ST_FINISH
    } state_t;

endpackage

// ===== hdl/periodic_task_dispatcher.sv =====
// Periodic task dispatcher. Requests arrive on the s_ stream with the opcode on
// s_tuser; results leave on the m_ stream, m_tlast marking the final result of
// a request. Every opcode but scan answers with one acknowledge, sent once the
// output register is free. A scan visits each registered task in turn: a
// disabled task is skipped in the read state, and an enabled task passes
// through a registered read of the task memories, an elapsed-time subtract
// and a compare against the interval. A scan also waits while the output
// register is still full. A new request is taken only when the previous
// one is finished; the last result may still be waiting in the output register.
// The wrap count is written through the cfg_ port; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module periodic_task_dispatcher #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    // task_select[3:0], ticks[36:4], initial_delay[69:37], start_enabled[70],
    // current_time[102:71], zero[103]
    input  logic [pdt_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  logic [pdt_pkg::S_TUSER_W-1:0]  s_tuser,

    output logic                           m_tvalid,
    input  logic                           m_tready,
    // kind[1:0], task_index[5:2], error[7:6]
    output logic [pdt_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pdt_pkg::CFG_W-1:0]      cfg_data
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int SEL_W = (CNT_W > 4) ? CNT_W : 4;

    // Low TIME_BITS bits of a 32-bit value.
    function automatic logic [TIME_BITS-1:0] to_time(input logic [31:0] v);
        logic [63:0] w;
        w = {32'd0, v};
        return w[TIME_BITS-1:0];
    endfunction

    // Low 32 bits of a time request, saturated to the timer width.
    function automatic logic [TIME_BITS-1:0] sat_time(input logic [31:0] v);
        logic [63:0] w;
        w = {32'd0, v};
        if ((w >> TIME_BITS) != 64'd0) begin
            return '1;
        end
        return w[TIME_BITS-1:0];
    endfunction

    pdt_pkg::state_t state_reg, state_next;

    logic [31:0]          wrap_reg;
    logic [2:0]           op_reg, op_next;
    logic [3:0]           sel_reg, sel_next;
    logic [32:0]          ticks_reg, ticks_next;
    logic [32:0]          init_reg, init_next;
    logic                 en_reg, en_next;
    logic [TIME_BITS-1:0] now_reg, now_next;

    logic [MAX_TASKS-1:0] pending_reg, pending_next;
    logic [MAX_TASKS-1:0] enable_reg, enable_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     cur_slot_reg, cur_slot_next;
    logic                 cur_valid_reg, cur_valid_next;

    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0]     hold_idx_reg, hold_idx_next;
    logic [TIME_BITS-1:0] delta_reg, delta_next;
    logic [TIME_BITS-1:0] interval_reg, interval_next;

    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           out_kind_reg, out_kind_next;
    logic [3:0]           out_idx_reg, out_idx_next;
    logic [1:0]           out_err_reg, out_err_next;
    logic                 out_last_reg, out_last_next;

    logic                 period_we, delay_we, last_we;
    logic [IDX_W-1:0]     period_waddr, delay_waddr, last_waddr;
    logic [TIME_BITS-1:0] period_wdata, delay_wdata, last_wdata;
    logic [TIME_BITS-1:0] period_q, delay_q, last_q;

    logic [IDX_W-1:0]     scan_addr;
    logic [IDX_W-1:0]     sel_idx;
    logic [IDX_W-1:0]     new_slot;
    logic [CNT_W-1:0]     scan_inc;
    logic                 sel_ok;
    logic                 out_free;
    logic [TIME_BITS-1:0] wrap_t;

    assign scan_addr = scan_reg[IDX_W-1:0];
    assign scan_inc  = scan_reg + CNT_W'(1);
    assign sel_idx   = IDX_W'(sel_reg);
    assign new_slot  = count_reg[IDX_W-1:0];
    assign sel_ok    = SEL_W'(sel_reg) < SEL_W'(count_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign wrap_t    = to_time(wrap_reg);

    assign s_tready  = (state_reg == pdt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_err_reg, out_idx_reg, out_kind_reg};
    assign m_tlast   = out_last_reg;

    pdt_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_period_ram (
        .aclk  (aclk),
        .we    (period_we),
        .waddr (period_waddr),
        .wdata (period_wdata),
        .raddr (scan_addr),
        .rdata (period_q)
    );

    pdt_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_delay_ram (
        .aclk  (aclk),
        .we    (delay_we),
        .waddr (delay_waddr),
        .wdata (delay_wdata),
        .raddr (scan_addr),
        .rdata (delay_q)
    );

    pdt_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TASKS)) u_last_ram (
        .aclk  (aclk),
        .we    (last_we),
        .waddr (last_waddr),
        .wdata (last_wdata),
        .raddr (scan_addr),
        .rdata (last_q)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        sel_next        = sel_reg;
        ticks_next      = ticks_reg;
        init_next       = init_reg;
        en_next         = en_reg;
        now_next        = now_reg;
        pending_next    = pending_reg;
        enable_next     = enable_reg;
        count_next      = count_reg;
        cur_slot_next   = cur_slot_reg;
        cur_valid_next  = cur_valid_reg;
        scan_next       = scan_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        delta_next      = delta_reg;
        interval_next   = interval_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        period_we    = 1'b0;
        period_waddr = new_slot;
        period_wdata = sat_time(ticks_reg[31:0]);
        delay_we     = 1'b0;
        delay_waddr  = new_slot;
        delay_wdata  = sat_time(ticks_reg[31:0]);
        last_we      = 1'b0;
        last_waddr   = new_slot;
        last_wdata   = '0;

        case (state_reg)
            pdt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    sel_next   = s_tdata[pdt_pkg::SEL_LSB +: 4];
                    ticks_next = s_tdata[pdt_pkg::TICKS_LSB +: 33];
                    init_next  = s_tdata[pdt_pkg::INIT_LSB +: 33];
                    en_next    = s_tdata[pdt_pkg::EN_BIT];
                    now_next   = to_time(s_tdata[pdt_pkg::NOW_LSB +: 32]);
                    if (s_tuser == pdt_pkg::OP_SCAN) begin
                        scan_next       = '0;
                        hold_valid_next = 1'b0;
                        state_next      = (count_reg == '0) ? pdt_pkg::ST_FINISH
                                                            : pdt_pkg::ST_READ;
                    end else begin
                        state_next = pdt_pkg::ST_EXEC;
                    end
                end
            end

            pdt_pkg::ST_EXEC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pdt_pkg::KIND_ACK;
                    out_idx_next   = 4'd0;
                    out_err_next   = pdt_pkg::ERR_OK;
                    out_last_next  = 1'b1;
                    state_next     = pdt_pkg::ST_IDLE;
                    case (op_reg)
                        pdt_pkg::OP_REGISTER: begin
                            if (count_reg == CNT_W'(MAX_TASKS)) begin
                                out_err_next = pdt_pkg::ERR_FULL;
                            end else if (ticks_reg[32]) begin
                                out_err_next = pdt_pkg::ERR_NO_CURRENT;
                            end else begin
                                period_we             = 1'b1;
                                last_we               = 1'b1;
                                delay_wdata           = sat_time(init_reg[31:0]);
                                delay_we              = !init_reg[32];
                                pending_next[new_slot] = !init_reg[32];
                                enable_next[new_slot]  = en_reg;
                                count_next            = count_reg + CNT_W'(1);
                                out_idx_next          = 4'(new_slot);
                            end
                        end
                        pdt_pkg::OP_RESTART, pdt_pkg::OP_PAUSE,
                        pdt_pkg::OP_SET_DELAY: begin
                            out_idx_next = sel_reg;
                            if (!sel_ok) begin
                                out_err_next = pdt_pkg::ERR_UNUSED;
                            end else if (op_reg == pdt_pkg::OP_RESTART) begin
                                enable_next[sel_idx] = 1'b1;
                            end else if (op_reg == pdt_pkg::OP_PAUSE) begin
                                enable_next[sel_idx] = 1'b0;
                            end else begin
                                delay_waddr           = sel_idx;
                                delay_we              = !ticks_reg[32];
                                pending_next[sel_idx] = !ticks_reg[32];
                            end
                        end
                        pdt_pkg::OP_SET_OWN: begin
                            if (!cur_valid_reg) begin
                                out_err_next = pdt_pkg::ERR_NO_CURRENT;
                            end else begin
                                delay_waddr                = cur_slot_reg;
                                delay_we                   = !ticks_reg[32];
                                pending_next[cur_slot_reg] = !ticks_reg[32];
                                out_idx_next               = 4'(cur_slot_reg);
                            end
                        end
                        default: begin
                            // Unknown opcodes only acknowledge.
                        end
                    endcase
                end
            end

            pdt_pkg::ST_READ: begin
                // The task memories are addressed by the scan index here.
                if (enable_reg[scan_addr]) begin
                    state_next = pdt_pkg::ST_DELTA;
                end else begin
                    scan_next  = scan_inc;
                    state_next = (scan_inc == count_reg) ? pdt_pkg::ST_FINISH
                                                         : pdt_pkg::ST_READ;
                end
            end

            pdt_pkg::ST_DELTA: begin
                if (now_reg < last_q) begin
                    delta_next = wrap_t - last_q + now_reg;
                end else begin
                    delta_next = now_reg - last_q;
                end
                interval_next = pending_reg[scan_addr] ? delay_q : period_q;
                state_next    = pdt_pkg::ST_COMPARE;
            end

            pdt_pkg::ST_COMPARE: begin
                if (delta_reg < interval_reg) begin
                    scan_next  = scan_inc;
                    state_next = (scan_inc == count_reg) ? pdt_pkg::ST_FINISH
                                                         : pdt_pkg::ST_READ;
                end else if (!hold_valid_reg || out_free) begin
                    // The previous dispatch is sent now that another one
                    // follows it; this one is held until another follows or the scan ends.
                    if (hold_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = pdt_pkg::KIND_DISPATCH;
                        out_idx_next   = 4'(hold_idx_reg);
                        out_err_next   = pdt_pkg::ERR_OK;
                        out_last_next  = 1'b0;
                    end
                    last_we                 = 1'b1;
                    last_waddr              = scan_addr;
                    last_wdata              = now_reg;
                    pending_next[scan_addr] = 1'b0;
                    cur_slot_next           = scan_addr;
                    cur_valid_next          = 1'b1;
                    hold_valid_next         = 1'b1;
                    hold_idx_next           = scan_addr;
                    scan_next               = scan_inc;
                    state_next = (scan_inc == count_reg) ? pdt_pkg::ST_FINISH
                                                         : pdt_pkg::ST_READ;
                end
            end

            pdt_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_err_next   = pdt_pkg::ERR_OK;
                    out_last_next  = 1'b1;
                    if (hold_valid_reg) begin
                        out_kind_next = pdt_pkg::KIND_DISPATCH;
                        out_idx_next  = 4'(hold_idx_reg);
                    end else begin
                        out_kind_next = pdt_pkg::KIND_NONE_DUE;
                        out_idx_next  = 4'd0;
                    end
                    state_next = pdt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = pdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pdt_pkg::ST_IDLE;
            wrap_reg       <= pdt_pkg::WRAP_RESET;
            pending_reg    <= '0;
            enable_reg     <= '0;
            count_reg      <= '0;
            cur_slot_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_valid) begin
                wrap_reg <= cfg_data;
            end
            pending_reg    <= pending_next;
            enable_reg     <= enable_next;
            count_reg      <= count_next;
            cur_slot_reg   <= cur_slot_next;
            cur_valid_reg  <= cur_valid_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        sel_reg      <= sel_next;
        ticks_reg    <= ticks_next;
        init_reg     <= init_next;
        en_reg       <= en_next;
        now_reg      <= now_next;
        scan_reg     <= scan_next;
        hold_idx_reg <= hold_idx_next;
        delta_reg    <= delta_next;
        interval_reg <= interval_next;
        out_kind_reg <= out_kind_next;
        out_idx_reg  <= out_idx_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

endmodule

// ===== hdl/pdt_ram.sv =====
module pdt_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
